// ===== rtl/csirs_pkg.sv =====
// CSI-RS pilot generator package: field widths, register indexes, row codes,
// QPSK amplitudes and the Gold sequence step and skip functions.
// No dependencies.
`timescale 1ns / 1ps
package csirs_pkg;

   localparam int unsigned GOLD_WIDTH        = 31;
   localparam int unsigned GOLD_SKIP_DEFAULT = 1600;

   localparam int unsigned BLOCK_WIDTH  = 9;
   localparam int unsigned INDEX_WIDTH  = 12;
   localparam int unsigned AMP_WIDTH    = 16;
   localparam int unsigned ROW_WIDTH    = 3;
   localparam int unsigned OFFSET_WIDTH = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = GOLD_WIDTH;

   localparam logic [OFFSET_WIDTH-1:0] RB_SUBCARRIERS = 4'd12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_ROW       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUBCARRIER_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEQUENCE_INIT     = 2'd2;

   localparam logic [ROW_WIDTH-1:0] ROW_FIXED_THREE = 3'd1;
   localparam logic [ROW_WIDTH-1:0] ROW_PAIR        = 3'd3;
   localparam logic [ROW_WIDTH-1:0] ROW_QUAD        = 3'd4;

   localparam logic signed [AMP_WIDTH-1:0] AMP_POS = 16'sd23170;
   localparam logic signed [AMP_WIDTH-1:0] AMP_NEG = -16'sd23170;

   typedef logic [GOLD_WIDTH-1:0] gold_word_type;
   typedef gold_word_type col_array_type [GOLD_WIDTH];

   typedef struct packed {
      logic advance;
      logic restart;
   } gold_ctrl_type;

   typedef struct packed {
      logic re_bit;
      logic im_bit;
   } gold_bits_type;

   typedef struct packed {
      logic          en;
      gold_word_type value;
   } seed_write_type;

   function automatic gold_word_type step_x1(gold_word_type r);
      return {r[0] ^ r[3], r[GOLD_WIDTH-1:1]};
   endfunction

   function automatic gold_word_type step_x2(gold_word_type r);
      return {r[0] ^ r[1] ^ r[2] ^ r[3], r[GOLD_WIDTH-1:1]};
   endfunction

   // elaboration only: x1 advanced n steps from one
   function automatic gold_word_type skip_x1(int unsigned n);
      gold_word_type r;
      r = gold_word_type'(1);
      for (int unsigned i = 0; i < n; i++) r = step_x1(r);
      return r;
   endfunction

   // elaboration only: columns of the n-step x2 transition matrix
   function automatic col_array_type skip_x2_cols(int unsigned n);
      col_array_type cols;
      gold_word_type r;
      for (int unsigned j = 0; j < GOLD_WIDTH; j++) begin
         r = gold_word_type'(1) << j;
         for (int unsigned i = 0; i < n; i++) r = step_x2(r);
         cols[j] = r;
      end
      return cols;
   endfunction

   function automatic gold_word_type apply_cols(col_array_type cols, gold_word_type v);
      gold_word_type acc;
      acc = '0;
      for (int unsigned j = 0; j < GOLD_WIDTH; j++) begin
         if (v[j]) acc = acc ^ cols[j];
      end
      return acc;
   endfunction

endpackage

// ===== rtl/csirs_gold.sv =====
// Gold sequence generator: x1 and x2 windows, two bits per pilot, restart
// from the pre-advanced seed. Depends on csirs_pkg.
`timescale 1ns / 1ps
module csirs_gold
   import csirs_pkg::*;
#(
   parameter int unsigned GOLD_SKIP = GOLD_SKIP_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  seed_write_type seed_wr,
   input  gold_ctrl_type  ctrl,
   output gold_bits_type  bits
);

   localparam gold_word_type X1_START = skip_x1(GOLD_SKIP);
   localparam col_array_type X2_COLS  = skip_x2_cols(GOLD_SKIP);

   gold_word_type x1_ff, x1_in;
   gold_word_type x2_ff, x2_in;
   gold_word_type seed_ff, seed_in;
   gold_word_type cur1, cur2;

   always_comb begin
      cur1    = ctrl.restart ? X1_START : x1_ff;
      cur2    = ctrl.restart ? seed_ff : x2_ff;
      bits.re_bit = cur1[0] ^ cur2[0];
      bits.im_bit = cur1[1] ^ cur2[1];
      x1_in   = ctrl.advance ? step_x1(step_x1(cur1)) : x1_ff;
      x2_in   = ctrl.advance ? step_x2(step_x2(cur2)) : x2_ff;
      seed_in = seed_wr.en ? apply_cols(X2_COLS, seed_wr.value) : seed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff   <= X1_START;
         x2_ff   <= '0;
         seed_ff <= '0;
      end else begin
         x1_ff   <= x1_in;
         x2_ff   <= x2_in;
         seed_ff <= seed_in;
      end
   end

endmodule

// ===== rtl/csi_rs_pilot_generator.sv =====
// Requests are registered in the item register, pilots in the rsp_ register.
// Throughput: one pilot per cycle unless rsp_ready stalls; a block of n pilots
// (1 to 4, set by pattern_row) holds the request register until its last pilot
// issues, and the next request can be accepted in that same cycle.
// Synchronous active-high reset: pattern_row 1, offset 0, init 0, Gold x1
// pre-advanced, x2 zero; no clearing pass.
`timescale 1ns / 1ps
module csi_rs_pilot_generator
   import csirs_pkg::*;
#(
   parameter int unsigned GOLD_SKIP = GOLD_SKIP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [BLOCK_WIDTH-1:0]        req_block_index,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [INDEX_WIDTH-1:0]        rsp_subcarrier_index,
   output logic signed [AMP_WIDTH-1:0]   rsp_real_part,
   output logic signed [AMP_WIDTH-1:0]   rsp_imag_part,
   output logic                          rsp_last_of_block
);

   logic [ROW_WIDTH-1:0]    row_ff, row_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;

   logic                    item_valid_ff, item_valid_in;
   logic [INDEX_WIDTH-1:0]  base_ff, base_in;
   logic                    restart_ff, restart_in;
   logic [1:0]              pilot_ff, pilot_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0]  rsp_index_ff, rsp_index_in;
   logic signed [AMP_WIDTH-1:0] rsp_re_ff, rsp_re_in;
   logic signed [AMP_WIDTH-1:0] rsp_im_ff, rsp_im_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept, issue, is_last;
   logic [1:0]              last_pilot;
   logic [OFFSET_WIDTH-1:0] k0;
   logic [4:0]              pilot_offset;
   logic [INDEX_WIDTH+1:0]  base_full;
   seed_write_type          seed_wr;
   gold_ctrl_type           gold_ctrl;
   gold_bits_type           gold_bits;

   csirs_gold #(.GOLD_SKIP(GOLD_SKIP)) u_gold (
      .clock   (clock),
      .reset   (reset),
      .seed_wr (seed_wr),
      .ctrl    (gold_ctrl),
      .bits    (gold_bits)
   );

   always_comb begin
      row_in    = row_ff;
      offset_in = offset_ff;
      seed_wr.en    = 1'b0;
      seed_wr.value = csr_data;
      if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_ROW:       row_in     = csr_data[ROW_WIDTH-1:0];
            CSR_SUBCARRIER_OFFSET: offset_in  = csr_data[OFFSET_WIDTH-1:0];
            CSR_SEQUENCE_INIT:     seed_wr.en = 1'b1;
            default:               row_in     = row_ff;
         endcase
      end

      case (row_ff)
         ROW_FIXED_THREE: last_pilot = 2'd2;
         ROW_PAIR:        last_pilot = 2'd1;
         ROW_QUAD:        last_pilot = 2'd3;
         default:         last_pilot = 2'd0;
      endcase

      k0 = (offset_ff >= RB_SUBCARRIERS) ? offset_ff - RB_SUBCARRIERS : offset_ff;
      if (row_ff == ROW_FIXED_THREE) begin
         pilot_offset = {1'b0, pilot_ff, 2'b00};
      end else begin
         pilot_offset = {1'b0, k0} + {2'b00, pilot_ff, 1'b0};
      end

      issue     = item_valid_ff && (!rsp_valid_ff || rsp_ready);
      is_last   = (pilot_ff == last_pilot);
      req_ready = !item_valid_ff || (issue && is_last);
      accept    = req_valid && req_ready;

      gold_ctrl.advance = issue;
      gold_ctrl.restart = restart_ff;

      base_full = {2'b00, 3'b000, req_block_index} * 14'd12;

      item_valid_in = item_valid_ff;
      base_in       = base_ff;
      restart_in    = restart_ff;
      pilot_in      = pilot_ff;
      if (accept) begin
         item_valid_in = 1'b1;
         base_in       = base_full[INDEX_WIDTH-1:0];
         restart_in    = req_restart;
         pilot_in      = 2'd0;
      end else if (issue) begin
         item_valid_in = !is_last;
         restart_in    = 1'b0;
         pilot_in      = pilot_ff + 2'd1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_last_in  = rsp_last_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = base_ff + {{(INDEX_WIDTH-5){1'b0}}, pilot_offset};
         rsp_re_in    = gold_bits.re_bit ? AMP_NEG : AMP_POS;
         rsp_im_in    = gold_bits.im_bit ? AMP_NEG : AMP_POS;
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= ROW_FIXED_THREE;
         offset_ff     <= '0;
         item_valid_ff <= 1'b0;
         restart_ff    <= 1'b0;
         pilot_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_ff        <= row_in;
         offset_ff     <= offset_in;
         item_valid_ff <= item_valid_in;
         restart_ff    <= restart_in;
         pilot_ff      <= pilot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      base_ff      <= base_in;
      rsp_index_ff <= rsp_index_in;
      rsp_re_ff    <= rsp_re_in;
      rsp_im_ff    <= rsp_im_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_subcarrier_index = rsp_index_ff;
   assign rsp_real_part        = rsp_re_ff;
   assign rsp_imag_part        = rsp_im_ff;
   assign rsp_last_of_block    = rsp_last_ff;

endmodule
